// ===== rtl/core/sml_pkg.sv =====
package sml_pkg;

    // defaults for the top-level parameters
    localparam int unsigned DEF_TABLE_DEPTH = 1024;
    localparam int unsigned DEF_NAME_LEN    = 32;

    // longest name stream one lookup returns
    localparam int unsigned MAX_RESULTS = 32;

    // width of the reported entry index
    localparam int unsigned IDX_W = 10;

    localparam logic [7:0] CHAR_NL = 8'h0A;
    localparam logic [7:0] CHAR_SP = 8'h20;

    // one input transaction
    typedef struct packed {
        logic        func;
        logic [7:0]  map_byte;
        logic [31:0] query_address;
    } t_in;

    // one result transaction
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] entry_index;
        logic [31:0]      symbol_address;
        logic [7:0]       symbol_type;
        logic [7:0]       name_char;
        logic             char_valid;
        logic             last;
    } t_out;

    // write strobes from the line parser to the table
    typedef struct packed {
        logic entry_we;
        logic name_we;
    } t_wr_ctl;

    typedef enum logic [1:0] {
        PH_ADDR,
        PH_TYPE,
        PH_SEP,
        PH_NAME
    } t_phase;

    typedef enum logic [2:0] {
        LK_IDLE,
        LK_RD,
        LK_CMP,
        LK_INFO,
        LK_LEN,
        LK_NRD,
        LK_EMIT,
        LK_MISS
    } t_lk_state;

endpackage

// ===== rtl/core/sml_parse.sv =====
module sml_parse #(
    parameter int unsigned TABLE_DEPTH = 1024,
    parameter int unsigned NAME_LEN    = 32,
    parameter int unsigned EW          = $clog2(TABLE_DEPTH),
    parameter int unsigned CW          = $clog2(TABLE_DEPTH + 1),
    parameter int unsigned LW          = $clog2(NAME_LEN + 1),
    parameter int unsigned NPW         = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [7:0]       i_byte,
    output sml_pkg::t_wr_ctl o_wr,
    output logic [EW-1:0]    o_wr_idx,
    output logic [31:0]      o_wr_addr,
    output logic [7:0]       o_wr_type,
    output logic [LW-1:0]    o_wr_len,
    output logic [EW+NPW-1:0] o_name_idx,
    output logic [7:0]       o_name_byte,
    output logic [CW-1:0]    o_count
);
    import sml_pkg::*;

    t_phase        r_phase, n_phase;
    logic [31:0]   r_acc, n_acc;
    logic [7:0]    r_type, n_type;
    logic [LW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_count, n_count;
    logic          room;
    logic          commit;

    function automatic logic [3:0] hex_value(input logic [7:0] b);
        logic [3:0] v;
        v = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            v = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = 4'(b - 8'h37);
        end
        return v;
    endfunction

    assign room = (r_count < CW'(TABLE_DEPTH));

    // line phase
    always_comb begin
        n_phase = r_phase;
        if (i_load) begin
            unique case (r_phase)
                PH_ADDR: begin
                    if (i_byte == CHAR_SP) begin
                        n_phase = PH_TYPE;
                    end
                end
                PH_TYPE: n_phase = PH_SEP;
                PH_SEP:  n_phase = PH_NAME;
                PH_NAME: begin
                    if (i_byte == CHAR_NL) begin
                        n_phase = PH_ADDR;
                    end
                end
                default: n_phase = PH_ADDR;
            endcase
        end
    end

    // line fields and table writes
    always_comb begin
        n_acc   = r_acc;
        n_type  = r_type;
        n_pos   = r_pos;
        n_count = r_count;
        commit  = 1'b0;
        o_wr    = '0;
        if (i_load) begin
            unique case (r_phase)
                PH_ADDR: begin
                    if (i_byte == CHAR_NL) begin
                        commit = 1'b1;
                    end else if (i_byte != CHAR_SP) begin
                        n_acc = {r_acc[27:0], hex_value(i_byte)};
                    end
                end
                PH_TYPE: n_type = i_byte;
                PH_SEP:  ;
                PH_NAME: begin
                    if (i_byte == CHAR_NL) begin
                        commit = 1'b1;
                    end else if (r_pos < LW'(NAME_LEN)) begin
                        n_pos        = r_pos + LW'(1);
                        o_wr.name_we = room;
                    end
                end
                default: ;
            endcase
        end
        if (commit) begin
            o_wr.entry_we = room;
            if (room) begin
                n_count = r_count + CW'(1);
            end
            n_acc  = '0;
            n_type = '0;
            n_pos  = '0;
        end
    end

    assign o_wr_idx    = r_count[EW-1:0];
    assign o_wr_addr   = r_acc;
    assign o_wr_type   = r_type;
    assign o_wr_len    = r_pos;
    assign o_name_idx  = {r_count[EW-1:0], r_pos[NPW-1:0]};
    assign o_name_byte = i_byte;
    assign o_count     = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_ADDR;
            r_acc   <= '0;
            r_type  <= '0;
            r_pos   <= '0;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_type  <= n_type;
            r_pos   <= n_pos;
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_pos_only_in_name: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_NAME) |-> (r_pos == '0))
        else $error("name position set outside name phase");
`endif

endmodule

// ===== rtl/core/sml_table.sv =====
module sml_table #(
    parameter int unsigned TABLE_DEPTH = 1024,
    parameter int unsigned NAME_LEN    = 32,
    parameter int unsigned EW          = $clog2(TABLE_DEPTH),
    parameter int unsigned LW          = $clog2(NAME_LEN + 1),
    parameter int unsigned NPW         = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1
) (
    input  logic              i_clk,
    input  sml_pkg::t_wr_ctl  i_wr,
    input  logic [EW-1:0]     i_wr_idx,
    input  logic [31:0]       i_wr_addr,
    input  logic [7:0]        i_wr_type,
    input  logic [LW-1:0]     i_wr_len,
    input  logic [EW+NPW-1:0] i_name_widx,
    input  logic [7:0]        i_name_wbyte,
    input  logic [EW-1:0]     i_addr_ridx,
    output logic [31:0]       o_addr_rdata,
    input  logic [EW-1:0]     i_info_ridx,
    output logic [7:0]        o_type_rdata,
    output logic [LW-1:0]     o_len_rdata,
    input  logic [EW+NPW-1:0] i_name_ridx,
    output logic [7:0]        o_name_rdata
);
    import sml_pkg::*;

    localparam int unsigned NAME_DEPTH = TABLE_DEPTH * (1 << NPW);

    logic [31:0]   r_addr_mem [TABLE_DEPTH];
    logic [7:0]    r_type_mem [TABLE_DEPTH];
    logic [LW-1:0] r_len_mem  [TABLE_DEPTH];
    logic [7:0]    r_name_mem [NAME_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.entry_we) begin
            r_addr_mem[i_wr_idx] <= i_wr_addr;
            r_type_mem[i_wr_idx] <= i_wr_type;
            r_len_mem[i_wr_idx]  <= i_wr_len;
        end
        if (i_wr.name_we) begin
            r_name_mem[i_name_widx] <= i_name_wbyte;
        end
    end

    always_ff @(posedge i_clk) begin
        o_addr_rdata <= r_addr_mem[i_addr_ridx];
        o_type_rdata <= r_type_mem[i_info_ridx];
        o_len_rdata  <= r_len_mem[i_info_ridx];
        o_name_rdata <= r_name_mem[i_name_ridx];
    end

endmodule

// ===== rtl/core/sml_lookup.sv =====
module sml_lookup #(
    parameter int unsigned TABLE_DEPTH = 1024,
    parameter int unsigned NAME_LEN    = 32,
    parameter int unsigned EW          = $clog2(TABLE_DEPTH),
    parameter int unsigned CW          = $clog2(TABLE_DEPTH + 1),
    parameter int unsigned LW          = $clog2(NAME_LEN + 1),
    parameter int unsigned NPW         = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [31:0]       i_query,
    input  logic [CW-1:0]     i_count,
    output logic [EW-1:0]     o_addr_ridx,
    input  logic [31:0]       i_addr_rdata,
    output logic [EW-1:0]     o_info_ridx,
    input  logic [7:0]        i_type_rdata,
    input  logic [LW-1:0]     i_len_rdata,
    output logic [EW+NPW-1:0] o_name_ridx,
    input  logic [7:0]        i_name_rdata,
    output logic              o_busy,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output sml_pkg::t_out     o_out_data
);
    import sml_pkg::*;

    localparam int unsigned STREAM_MAX = (NAME_LEN < MAX_RESULTS) ? NAME_LEN : MAX_RESULTS;

    t_lk_state     r_state, n_state;
    logic [31:0]   r_q;
    logic [CW-1:0] r_j;
    logic          r_prev_le;
    logic [31:0]   r_prev_addr;
    logic [EW-1:0] r_hit;
    logic [7:0]    r_type;
    logic [LW-1:0] r_len;
    logic [LW-1:0] r_k;
    logic          r_out_vld;
    t_out          r_out, n_out;

    logic          le;
    logic          hit;
    logic          scan_done;
    logic          slot_free;
    logic          last_now;
    logic          out_load;
    logic [CW-1:0] j_prev;
    logic [LW-1:0] eff_len;
    logic [31:0]   hit_wide;

    // shared compare: stored start address against the query
    assign le        = (i_addr_rdata <= r_q);
    assign hit       = (r_j != '0) && r_prev_le && !le;
    assign scan_done = (r_j == i_count);
    assign slot_free = !r_out_vld || !i_out_stall;
    assign last_now  = (r_len == '0) || ((r_k + LW'(1)) == r_len);
    assign j_prev    = r_j - CW'(1);
    assign eff_len   = (i_len_rdata > LW'(STREAM_MAX)) ? LW'(STREAM_MAX) : i_len_rdata;
    assign hit_wide  = 32'(r_hit);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            LK_IDLE: if (i_start) n_state = LK_RD;
            LK_RD:   n_state = scan_done ? LK_MISS : LK_CMP;
            LK_CMP:  n_state = hit ? LK_INFO : LK_RD;
            LK_INFO: n_state = LK_LEN;
            LK_LEN:  n_state = LK_NRD;
            LK_NRD:  n_state = LK_EMIT;
            LK_EMIT: begin
                if (slot_free) begin
                    n_state = last_now ? LK_IDLE : LK_NRD;
                end
            end
            LK_MISS: if (slot_free) n_state = LK_IDLE;
            default: n_state = LK_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        out_load = 1'b0;
        n_out    = '0;
        unique case (r_state)
            LK_EMIT: begin
                out_load             = slot_free;
                n_out.found          = 1'b1;
                n_out.entry_index    = hit_wide[IDX_W-1:0];
                n_out.symbol_address = r_prev_addr;
                n_out.symbol_type    = r_type;
                n_out.last           = last_now;
                if (r_len != '0) begin
                    n_out.name_char  = i_name_rdata;
                    n_out.char_valid = 1'b1;
                end
            end
            LK_MISS: begin
                out_load   = slot_free;
                n_out.last = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_addr_ridx = r_j[EW-1:0];
    assign o_info_ridx = r_hit;
    assign o_name_ridx = {r_hit, r_k[NPW-1:0]};
    assign o_busy      = (r_state != LK_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= LK_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == LK_IDLE && i_start) begin
            r_q       <= i_query;
            r_j       <= '0;
            r_prev_le <= 1'b0;
        end
        if (r_state == LK_CMP) begin
            if (hit) begin
                r_hit <= j_prev[EW-1:0];
            end else begin
                r_prev_le   <= le;
                r_prev_addr <= i_addr_rdata;
                r_j         <= r_j + CW'(1);
            end
        end
        if (r_state == LK_LEN) begin
            r_type <= i_type_rdata;
            r_len  <= eff_len;
            r_k    <= '0;
        end
        if (r_state == LK_EMIT && slot_free && !last_now) begin
            r_k <= r_k + LW'(1);
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.found) |->
            (r_out.last && !r_out.char_valid && r_out.entry_index == '0))
        else $error("miss result carries entry data");

    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == LK_EMIT) && (r_len != '0)) |-> (r_k < r_len))
        else $error("name byte counter past stream length");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == LK_CMP) |-> (r_j < i_count))
        else $error("scan compare beyond committed entries");
`endif

endmodule

// ===== rtl/core/symbol_map_load_and_lookup_core.sv =====
// load transaction: one map byte taken every cycle while no lookup is in progress, no result
// lookup: accepted when idle, then each table entry is scanned by the shared address
//   compare (LK_RD, LK_CMP), then setup (LK_INFO, LK_LEN) and each result (name byte) through
//   LK_NRD, LK_EMIT and one output register, waiting while the output side stalls
// input is stalled from lookup accept until its last result sits in the output register
// synchronous active-low reset empties the table (entry count to zero) and the line parser;
//   the table memories themselves are not cleared and need no clearing pass
module symbol_map_load_and_lookup_core #(
    parameter int unsigned TABLE_DEPTH = sml_pkg::DEF_TABLE_DEPTH,
    parameter int unsigned NAME_LEN    = sml_pkg::DEF_NAME_LEN
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sml_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output sml_pkg::t_out o_out_data
);
    import sml_pkg::*;

    // entry index, entry count, name length and name slot widths
    localparam int unsigned EW  = $clog2(TABLE_DEPTH);
    localparam int unsigned CW  = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned LW  = $clog2(NAME_LEN + 1);
    localparam int unsigned NPW = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;

    logic              in_take;
    logic              load_take;
    logic              lookup_take;
    logic              busy;

    t_wr_ctl           wr;
    logic [EW-1:0]     wr_idx;
    logic [31:0]       wr_addr;
    logic [7:0]        wr_type;
    logic [LW-1:0]     wr_len;
    logic [EW+NPW-1:0] name_widx;
    logic [7:0]        name_wbyte;
    logic [CW-1:0]     count;

    logic [EW-1:0]     addr_ridx;
    logic [31:0]       addr_rdata;
    logic [EW-1:0]     info_ridx;
    logic [7:0]        type_rdata;
    logic [LW-1:0]     len_rdata;
    logic [EW+NPW-1:0] name_ridx;
    logic [7:0]        name_rdata;

    // a transaction is taken whenever the lookup sequencer is idle
    assign o_in_stall  = busy;
    assign in_take     = i_in_valid && !busy;
    assign load_take   = in_take && !i_in_data.func;
    assign lookup_take = in_take && i_in_data.func;

    // line parser: builds entries from map text bytes
    sml_parse #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .NAME_LEN    (NAME_LEN),
        .EW          (EW),
        .CW          (CW),
        .LW          (LW),
        .NPW         (NPW)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load_take),
        .i_byte      (i_in_data.map_byte),
        .o_wr        (wr),
        .o_wr_idx    (wr_idx),
        .o_wr_addr   (wr_addr),
        .o_wr_type   (wr_type),
        .o_wr_len    (wr_len),
        .o_name_idx  (name_widx),
        .o_name_byte (name_wbyte),
        .o_count     (count)
    );

    // symbol table memories, one write port and one registered read port each
    sml_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .NAME_LEN    (NAME_LEN),
        .EW          (EW),
        .LW          (LW),
        .NPW         (NPW)
    ) u_table (
        .i_clk        (i_clk),
        .i_wr         (wr),
        .i_wr_idx     (wr_idx),
        .i_wr_addr    (wr_addr),
        .i_wr_type    (wr_type),
        .i_wr_len     (wr_len),
        .i_name_widx  (name_widx),
        .i_name_wbyte (name_wbyte),
        .i_addr_ridx  (addr_ridx),
        .o_addr_rdata (addr_rdata),
        .i_info_ridx  (info_ridx),
        .o_type_rdata (type_rdata),
        .o_len_rdata  (len_rdata),
        .i_name_ridx  (name_ridx),
        .o_name_rdata (name_rdata)
    );

    // lookup sequencer: linear scan with one shared compare, then name streaming
    sml_lookup #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .NAME_LEN    (NAME_LEN),
        .EW          (EW),
        .CW          (CW),
        .LW          (LW),
        .NPW         (NPW)
    ) u_lookup (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (lookup_take),
        .i_query      (i_in_data.query_address),
        .i_count      (count),
        .o_addr_ridx  (addr_ridx),
        .i_addr_rdata (addr_rdata),
        .o_info_ridx  (info_ridx),
        .i_type_rdata (type_rdata),
        .i_len_rdata  (len_rdata),
        .o_name_ridx  (name_ridx),
        .i_name_rdata (name_rdata),
        .o_busy       (busy),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

endmodule
